>>> rtl/itoa_pkg.sv
// Package for the signed integer to decimal ASCII converter: types and constants.
`default_nettype none
package itoa_pkg;

    localparam int MAG_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CHAR_W     = 6;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 4;

    localparam logic [CNT_W-1:0] LAST_SHIFT = CNT_W'(MAG_W - 1);
    localparam logic [IDX_W-1:0] TOP_DIGIT  = IDX_W'(NUM_DIGITS - 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ     = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

>>> rtl/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII characters, most significant first.
// One value is taken at a time: the magnitude runs through a 32-step shift-add-3
// (binary to BCD) loop on one shared adjust/shift unit, one bit per cycle, then a
// minus sign is sent for negative values, then the digits are scanned from the top,
// skipping leading zeros one per cycle, and one character is sent per cycle while
// the output is not stalled. A new request is taken only once the previous value
// is done: the accept step, the BCD loop, the sign for negative values, and a step
// for each of the ten digit positions, skipped or sent. A character that waits in
// the output register holds up the next character to be sent.
// in_stall is high from the cycle after acceptance until the last character is
// loaded into the output register.
`default_nettype none
module signed_int_to_decimal_ascii (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [5:0]       character,
    output logic             last
);

    itoa_pkg::state_t state_reg, state_next;

    logic [itoa_pkg::MAG_W-1:0]  mag_reg, mag_next;
    logic [itoa_pkg::BCD_W-1:0]  bcd_reg, bcd_next;
    logic                        neg_reg, neg_next;
    logic [itoa_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [itoa_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic                        started_reg, started_next;
    logic                        out_valid_reg, out_valid_next;
    logic [itoa_pkg::CHAR_W-1:0] character_reg, character_next;
    logic                        last_reg, last_next;

    logic [itoa_pkg::BCD_W-1:0]  bcd_adj;
    logic [3:0]                  cur_digit;
    logic                        out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign cur_digit = bcd_reg[{idx_reg, 2'b00} +: 4];

    // shared adjust unit: add 3 to every BCD digit of 5 or more
    always_comb
    begin
        for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= itoa_pkg::BCD_ADJ_MIN)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + itoa_pkg::BCD_ADJ;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itoa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        bcd_reg       <= bcd_next;
        neg_reg       <= neg_next;
        cnt_reg       <= cnt_next;
        idx_reg       <= idx_next;
        started_reg   <= started_next;
        character_reg <= character_next;
        last_reg      <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && out_stall;
        character_next = character_reg;
        last_next      = last_reg;

        case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next   = value[31];
                    mag_next   = value[31] ? (~value + 32'd1) : value;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = itoa_pkg::ST_CONV;
                end
            end
            itoa_pkg::ST_CONV:
            begin
                bcd_next = {bcd_adj[itoa_pkg::BCD_W-2:0], mag_reg[itoa_pkg::MAG_W-1]};
                mag_next = {mag_reg[itoa_pkg::MAG_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                idx_next = itoa_pkg::TOP_DIGIT;
                started_next = 1'b0;
                if (cnt_reg == itoa_pkg::LAST_SHIFT)
                    state_next = neg_reg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
            end
            itoa_pkg::ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    character_next = itoa_pkg::CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = itoa_pkg::ST_EMIT;
                end
            end
            itoa_pkg::ST_EMIT:
            begin
                // leading zero: skip, except the ones digit which always goes out
                if (cur_digit == 4'd0 && !started_reg && idx_reg != '0)
                    idx_next = idx_reg - 1'b1;
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    character_next = itoa_pkg::CHAR_ZERO + {2'b00, cur_digit};
                    last_next      = (idx_reg == '0);
                    started_next   = 1'b1;
                    if (idx_reg == '0)
                        state_next = itoa_pkg::ST_IDLE;
                    else
                        idx_next = idx_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = itoa_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != itoa_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last      = last_reg;

endmodule
`default_nettype wire
